// ===== rtl/core/led_string_pulse_frame_encoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// led string pulse frame encoder - assertion macros
// Shared concurrent assertion shorthands for the encoder core.
// ----------------------------------------------------------------------------
`ifndef LED_STRING_PULSE_FRAME_ENCODER_CORE_MACROS_SVH
`define LED_STRING_PULSE_FRAME_ENCODER_CORE_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define LSPFE_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LSPFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lspfe_pkg.sv =====
// ----------------------------------------------------------------------------
// lspfe_pkg
// Types and constants shared by the led string pulse frame encoder core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lspfe_pkg;

    // frame layout
    localparam int FRAME_BITS = 26;
    localparam int SEG_COUNT  = 2 * FRAME_BITS + 1;
    localparam int SEG_W      = $clog2(SEG_COUNT);

    // field widths
    localparam int STRAND_W   = 3;
    localparam int ADDR_W     = 6;
    localparam int INTENS_W   = 8;
    localparam int COLOUR_W   = 4;
    localparam int DUR_W      = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_TIME     = 3'd0,
        REG_ONE_LOW_TIME   = 3'd1,
        REG_ONE_HIGH_TIME  = 3'd2,
        REG_ZERO_LOW_TIME  = 3'd3,
        REG_ZERO_HIGH_TIME = 3'd4
    } cfg_reg_t;

    // register reset values
    localparam logic [DUR_W-1:0] START_TIME_RST     = 8'd8;
    localparam logic [DUR_W-1:0] ONE_LOW_TIME_RST   = 8'd19;
    localparam logic [DUR_W-1:0] ONE_HIGH_TIME_RST  = 8'd8;
    localparam logic [DUR_W-1:0] ZERO_LOW_TIME_RST  = 8'd9;
    localparam logic [DUR_W-1:0] ZERO_HIGH_TIME_RST = 8'd18;

    // pulse timing set handed to the back end
    typedef struct packed {
        logic [DUR_W-1:0] start_time;
        logic [DUR_W-1:0] one_low_time;
        logic [DUR_W-1:0] one_high_time;
        logic [DUR_W-1:0] zero_low_time;
        logic [DUR_W-1:0] zero_high_time;
    } timing_t;

    // packed bulb command
    typedef struct packed {
        logic [STRAND_W-1:0]   strand;
        logic [FRAME_BITS-1:0] word;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/lspfe_front.sv =====
// ----------------------------------------------------------------------------
// lspfe_front
// Accepts bulb commands, drops those for absent strands and packs the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lspfe_front
    import lspfe_pkg::*;
#(
    parameter int STRAND_COUNT = 5
) (
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [STRAND_W-1:0]   s_strand,
    input  wire logic [ADDR_W-1:0]     s_bulb_address,
    input  wire logic [INTENS_W-1:0]   s_intensity,
    input  wire logic [COLOUR_W-1:0]   s_blue,
    input  wire logic [COLOUR_W-1:0]   s_green,
    input  wire logic [COLOUR_W-1:0]   s_red,
    output logic                       push,
    output cmd_t                       push_cmd,
    input  wire logic                  queue_ready
);

    logic strand_ok;

    // strand range check, one bit wider so a count of eight fits
    assign strand_ok = ({1'b0, s_strand} < (STRAND_W + 1)'(STRAND_COUNT));

    // transfer whenever the queue has room; absent strands are consumed silently
    assign s_ready = queue_ready;
    assign push    = s_valid && queue_ready && strand_ok;

    // frame word, most significant first
    assign push_cmd.strand = s_strand;
    assign push_cmd.word   = {s_bulb_address, s_intensity, s_blue, s_green, s_red};

endmodule

`default_nettype wire

// ===== rtl/core/lspfe_queue.sv =====
// ----------------------------------------------------------------------------
// lspfe_queue
// Short command queue decoupling the front end from the segment generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lspfe_queue
    import lspfe_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      push_ready,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_cmd
);

    cmd_t                   entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop && pop_valid;

    // pointer and fill level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lspfe_back.sv =====
// ----------------------------------------------------------------------------
// lspfe_back
// Segment generator: walks one frame, one line segment per cycle while m_ready allows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lspfe_back
    import lspfe_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cmd_valid,
    input  wire cmd_t                cmd,
    output logic                     cmd_pop,
    input  wire timing_t             timing,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STRAND_W-1:0]      m_line_strand,
    output logic                     m_level,
    output logic [DUR_W-1:0]         m_duration,
    output logic                     m_last
);

    logic                  busy_reg, busy_next;
    logic [SEG_W-1:0]      seg_reg, seg_next;
    logic [FRAME_BITS-1:0] word_reg, word_next;
    logic [STRAND_W-1:0]   strand_reg, strand_next;

    logic                  m_valid_reg, m_valid_next;
    logic [STRAND_W-1:0]   m_strand_reg;
    logic                  m_level_reg;
    logic [DUR_W-1:0]      m_duration_reg;
    logic                  m_last_reg;

    logic                  advance, emit, seg_final, bit_one;
    logic                  seg_level;
    logic [DUR_W-1:0]      seg_duration;

    // output register frees up when empty or being taken
    assign advance   = !m_valid_reg || m_ready;
    assign emit      = busy_reg && advance;
    assign seg_final = (seg_reg == SEG_W'(SEG_COUNT - 1));
    assign cmd_pop   = cmd_valid && advance && (!busy_reg || seg_final);
    assign bit_one   = word_reg[FRAME_BITS-1];

    // current segment: start pulse, then low/high pair per bit
    always_comb begin
        if (seg_reg == '0) begin
            seg_level    = 1'b1;
            seg_duration = timing.start_time;
        end else if (seg_reg[0]) begin
            seg_level    = 1'b0;
            seg_duration = bit_one ? timing.one_low_time : timing.zero_low_time;
        end else begin
            seg_level    = 1'b1;
            seg_duration = bit_one ? timing.one_high_time : timing.zero_high_time;
        end
    end

    // frame walker
    always_comb begin
        busy_next   = busy_reg;
        seg_next    = seg_reg;
        word_next   = word_reg;
        strand_next = strand_reg;
        if (emit) begin
            seg_next = seg_reg + 1'b1;
            if (!seg_reg[0] && seg_reg != '0) begin
                word_next = {word_reg[FRAME_BITS-2:0], 1'b0};
            end
            if (seg_final) begin
                busy_next = 1'b0;
            end
        end
        if (cmd_pop) begin
            busy_next   = 1'b1;
            seg_next    = '0;
            word_next   = cmd.word;
            strand_next = cmd.strand;
        end
    end

    assign m_valid_next = advance ? emit : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            seg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            seg_reg     <= seg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // frame payload and output payload
    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        strand_reg <= strand_next;
        if (emit) begin
            m_strand_reg   <= strand_reg;
            m_level_reg    <= seg_level;
            m_duration_reg <= seg_duration;
            m_last_reg     <= seg_final;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_line_strand = m_strand_reg;
    assign m_level       = m_level_reg;
    assign m_duration    = m_duration_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/led_string_pulse_frame_encoder_core.sv =====
// ----------------------------------------------------------------------------
// led_string_pulse_frame_encoder_core
// Turns bulb commands into pulse-width coded line segments for LED strands.
// ----------------------------------------------------------------------------
// Usage
//   s_* channel: one bulb command per transfer (strand, address, intensity,
//   blue, green, red). The 26-bit frame word is sent most significant first.
//   m_* channel: one line segment per transfer (strand, level, duration,
//   last). A frame is 53 segments: high start pulse, then low/high per bit,
//   with m_last on the final high phase.
//   cfg_*: plain register write port for the five pulse timings; write only
//   while no frame is in progress.
// Timing
//   the first segment passes the command queue, the back-end frame registers
//   and the output register; one segment per cycle from the segment counter in
//   the back end while m_ready allows; frames follow each other without a gap.
//   Commands for a strand at or above STRAND_COUNT are taken and dropped.
// Reset and stall
//   aresetn (synchronous, active low) empties the queue, stops any frame and
//   restores the default timings. When m_ready is low the segment is held;
//   the two-entry command queue keeps s_ready high until it fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_string_pulse_frame_encoder_core_macros.svh"

module led_string_pulse_frame_encoder_core
    import lspfe_pkg::*;
#(
    parameter int STRAND_COUNT = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // command channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [STRAND_W-1:0]   s_strand,
    input  wire logic [ADDR_W-1:0]     s_bulb_address,
    input  wire logic [INTENS_W-1:0]   s_intensity,
    input  wire logic [COLOUR_W-1:0]   s_blue,
    input  wire logic [COLOUR_W-1:0]   s_green,
    input  wire logic [COLOUR_W-1:0]   s_red,
    // segment channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [STRAND_W-1:0]        m_line_strand,
    output logic                       m_level,
    output logic [DUR_W-1:0]           m_duration,
    output logic                       m_last,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    timing_t timing_reg, timing_next;
    logic    push, queue_ready, pop, pop_valid;
    cmd_t    push_cmd, pop_cmd;

    // timing register writes; unknown indexes are ignored
    always_comb begin
        timing_next = timing_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_START_TIME:     timing_next.start_time     = cfg_data;
                REG_ONE_LOW_TIME:   timing_next.one_low_time   = cfg_data;
                REG_ONE_HIGH_TIME:  timing_next.one_high_time  = cfg_data;
                REG_ZERO_LOW_TIME:  timing_next.zero_low_time  = cfg_data;
                REG_ZERO_HIGH_TIME: timing_next.zero_high_time = cfg_data;
                default:            timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.start_time     <= START_TIME_RST;
            timing_reg.one_low_time   <= ONE_LOW_TIME_RST;
            timing_reg.one_high_time  <= ONE_HIGH_TIME_RST;
            timing_reg.zero_low_time  <= ZERO_LOW_TIME_RST;
            timing_reg.zero_high_time <= ZERO_HIGH_TIME_RST;
        end else begin
            timing_reg <= timing_next;
        end
    end

    // front end: accept and classify
    lspfe_front #(
        .STRAND_COUNT (STRAND_COUNT)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_strand       (s_strand),
        .s_bulb_address (s_bulb_address),
        .s_intensity    (s_intensity),
        .s_blue         (s_blue),
        .s_green        (s_green),
        .s_red          (s_red),
        .push           (push),
        .push_cmd       (push_cmd),
        .queue_ready    (queue_ready)
    );

    // command queue
    lspfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (queue_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    // back end: segment generation
    lspfe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (pop_valid),
        .cmd           (pop_cmd),
        .cmd_pop       (pop),
        .timing        (timing_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_strand (m_line_strand),
        .m_level       (m_level),
        .m_duration    (m_duration),
        .m_last        (m_last)
    );

    // checks on the frame structure
    `LSPFE_ASSERT_RST(a_last_is_high, aclk, aresetn, (m_valid && m_last) |-> m_level, "last segment must be a high phase")
    `LSPFE_ASSERT_RST(a_frame_no_gap, aclk, aresetn, (m_valid && m_ready && !m_last) |=> m_valid, "gap inside a frame")
    `LSPFE_ASSERT_RST(a_strand_range, aclk, aresetn, m_valid |-> (4'(m_line_strand) < 4'(STRAND_COUNT)), "segment on absent strand")
    `LSPFE_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "segment valid straight after reset")

endmodule

`default_nettype wire

// ===== verif/lspfe_segment_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspfe_segment_checker
// Watches the command, segment and configuration ports of the frame encoder,
// predicts the 53 line segments of every taken command for a present strand from its own copy of
// the pulse timings, and compares each segment transfer field by field.
// ----------------------------------------------------------------------------
module lspfe_segment_checker
    import lspfe_pkg::*;
#(
    parameter int STRAND_COUNT = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [STRAND_W-1:0]   s_strand,
    input  logic [ADDR_W-1:0]     s_bulb_address,
    input  logic [INTENS_W-1:0]   s_intensity,
    input  logic [COLOUR_W-1:0]   s_blue,
    input  logic [COLOUR_W-1:0]   s_green,
    input  logic [COLOUR_W-1:0]   s_red,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [STRAND_W-1:0]   m_line_strand,
    input  logic                  m_level,
    input  logic [DUR_W-1:0]      m_duration,
    input  logic                  m_last,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    segs_pending,
    output int                    fail_count
);

    typedef struct packed {
        logic [STRAND_W-1:0] strand;
        logic                level;
        logic [DUR_W-1:0]    duration;
        logic                last;
    } line_seg_t;

    // predicted segments, oldest first
    line_seg_t frame_segments[$];

    // local copy of the pulse timings
    logic [DUR_W-1:0] start_t;
    logic [DUR_W-1:0] one_lo_t;
    logic [DUR_W-1:0] one_hi_t;
    logic [DUR_W-1:0] zero_lo_t;
    logic [DUR_W-1:0] zero_hi_t;

    // start pulse, then a low and a high phase per frame bit, msb first
    function automatic void encode_frame(input logic [STRAND_W-1:0] strand,
                                         input logic [FRAME_BITS-1:0] word);
        line_seg_t seg;
        seg.strand   = strand;
        seg.level    = 1'b1;
        seg.duration = start_t;
        seg.last     = 1'b0;
        frame_segments.push_back(seg);
        for (int b = FRAME_BITS - 1; b >= 0; b--) begin
            seg.level    = 1'b0;
            seg.duration = word[b] ? one_lo_t : zero_lo_t;
            seg.last     = 1'b0;
            frame_segments.push_back(seg);
            seg.level    = 1'b1;
            seg.duration = word[b] ? one_hi_t : zero_hi_t;
            seg.last     = (b == 0);
            frame_segments.push_back(seg);
        end
    endfunction

    // one field compare, 1 on mismatch
    function automatic int check_field(input string name, input logic [DUR_W-1:0] want,
                                       input logic [DUR_W-1:0] got);
        if (want === got)
            return 0;
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        return 1;
    endfunction

    // monitor: timing writes, segment compare, command prediction
    always @(posedge aclk) begin : seg_monitor
        line_seg_t want;
        int        errs;
        errs = 0;
        if (!aresetn) begin
            frame_segments.delete();
            start_t      <= START_TIME_RST;
            one_lo_t     <= ONE_LOW_TIME_RST;
            one_hi_t     <= ONE_HIGH_TIME_RST;
            zero_lo_t    <= ZERO_LOW_TIME_RST;
            zero_hi_t    <= ZERO_HIGH_TIME_RST;
            segs_pending <= 0;
            fail_count   <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_TIME:     start_t   <= cfg_data;
                    REG_ONE_LOW_TIME:   one_lo_t  <= cfg_data;
                    REG_ONE_HIGH_TIME:  one_hi_t  <= cfg_data;
                    REG_ZERO_LOW_TIME:  zero_lo_t <= cfg_data;
                    REG_ZERO_HIGH_TIME: zero_hi_t <= cfg_data;
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (frame_segments.size() == 0) begin
                    $error("unexpected segment: strand %0d level %0d duration %0d last %0d",
                           m_line_strand, m_level, m_duration, m_last);
                    errs = 1;
                end else begin
                    want = frame_segments.pop_front();
                    errs += check_field("line_strand", DUR_W'(want.strand),
                                        DUR_W'(m_line_strand));
                    errs += check_field("level", DUR_W'(want.level), DUR_W'(m_level));
                    errs += check_field("duration", want.duration, m_duration);
                    errs += check_field("last", DUR_W'(want.last), DUR_W'(m_last));
                end
            end

            // strands beyond the last data line are taken and dropped
            if (s_valid && s_ready && (s_strand < STRAND_COUNT))
                encode_frame(s_strand, {s_bulb_address, s_intensity, s_blue, s_green, s_red});

            segs_pending <= frame_segments.size();
            fail_count   <= fail_count + errs;
        end
    end

endmodule

// ===== verif/tb_led_string_pulse_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_string_pulse_frame_encoder_core
// Drives bulb commands and pulse timing writes into the frame encoder core,
// with random idling on both channels, one long segment back-pressure and
// drains between timing changes; the checker beside the block does the
// prediction and comparison, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_led_string_pulse_frame_encoder_core;
    import lspfe_pkg::*;

    localparam int STRAND_COUNT     = 5;
    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 8;
    localparam int IDLE_PERCENT     = 34;
    localparam int STALL_CYCLES     = 400;
    localparam int SETTLE_CYCLES    = 16;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 20;
    localparam int STEADY_PHASE     = 1;
    localparam int BACKPRESS_PHASE  = 3;
    localparam int STRAND_MAX       = (1 << STRAND_W) - 1;
    localparam int CFG_IDX_MAX      = (1 << CFG_IDX_W) - 1;
    localparam logic [DUR_W-1:0] DUR_MAX = '1;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [STRAND_W-1:0]   s_strand       = '0;
    logic [ADDR_W-1:0]     s_bulb_address = '0;
    logic [INTENS_W-1:0]   s_intensity    = '0;
    logic [COLOUR_W-1:0]   s_blue         = '0;
    logic [COLOUR_W-1:0]   s_green        = '0;
    logic [COLOUR_W-1:0]   s_red          = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [STRAND_W-1:0]   m_line_strand;
    logic                  m_level;
    logic [DUR_W-1:0]      m_duration;
    logic                  m_last;
    logic                  cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    int   segs_pending;
    int   fail_count;
    int   cycle_count = 0;
    int   stall_left  = 0;
    logic stall_start = 1'b0;
    logic src_steady  = 1'b0;
    logic snk_steady  = 1'b0;

    always #(HALF_PERIOD) aclk = ~aclk;

    led_string_pulse_frame_encoder_core #(
        .STRAND_COUNT(STRAND_COUNT)
    ) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_strand(s_strand),
        .s_bulb_address(s_bulb_address), .s_intensity(s_intensity),
        .s_blue(s_blue), .s_green(s_green), .s_red(s_red),
        .m_valid(m_valid), .m_ready(m_ready), .m_line_strand(m_line_strand),
        .m_level(m_level), .m_duration(m_duration), .m_last(m_last),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lspfe_segment_checker #(
        .STRAND_COUNT(STRAND_COUNT)
    ) i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_strand(s_strand),
        .s_bulb_address(s_bulb_address), .s_intensity(s_intensity),
        .s_blue(s_blue), .s_green(s_green), .s_red(s_red),
        .m_valid(m_valid), .m_ready(m_ready), .m_line_strand(m_line_strand),
        .m_level(m_level), .m_duration(m_duration), .m_last(m_last),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .segs_pending(segs_pending), .fail_count(fail_count)
    );

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_led_string_pulse_frame_encoder_core NOT OK");
            $finish;
        end
    end

    // segment receiver: random idling or steady ready, one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_start) begin
            m_ready    <= 1'b0;
            stall_left <= STALL_CYCLES;
        end else if (snk_steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // one command transfer, with a random gap in front
    task automatic send_cmd(input logic [STRAND_W-1:0] strand,
                            input logic [ADDR_W-1:0] addr,
                            input logic [INTENS_W-1:0] inten,
                            input logic [COLOUR_W-1:0] blue,
                            input logic [COLOUR_W-1:0] green,
                            input logic [COLOUR_W-1:0] red);
        while (!src_steady && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_strand       <= strand;
        s_bulb_address <= addr;
        s_intensity    <= inten;
        s_blue         <= blue;
        s_green        <= green;
        s_red          <= red;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // command with random payload
    task automatic send_random_payload(input logic [STRAND_W-1:0] strand);
        send_cmd(strand, ADDR_W'($urandom), INTENS_W'($urandom), COLOUR_W'($urandom),
                 COLOUR_W'($urandom), COLOUR_W'($urandom));
    endtask

    // mostly real strands, some that name no data line
    task automatic send_random_cmds(input int count);
        logic [STRAND_W-1:0] strand;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 85)
                strand = STRAND_W'($urandom_range(0, STRAND_COUNT - 1));
            else
                strand = STRAND_W'($urandom_range(STRAND_COUNT, STRAND_MAX));
            send_random_payload(strand);
        end
    endtask

    // stop offering, wait for every predicted segment, then let the block settle
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (segs_pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
    endtask

    task automatic program_timings(input logic [DUR_W-1:0] st, input logic [DUR_W-1:0] ol,
                                   input logic [DUR_W-1:0] oh, input logic [DUR_W-1:0] zl,
                                   input logic [DUR_W-1:0] zh);
        write_reg(REG_START_TIME, st);
        write_reg(REG_ONE_LOW_TIME, ol);
        write_reg(REG_ONE_HIGH_TIME, oh);
        write_reg(REG_ZERO_LOW_TIME, zl);
        write_reg(REG_ZERO_HIGH_TIME, zh);
        cfg_wr_en <= 1'b0;
    endtask

    // extremes turn up often
    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return DUR_MAX;
            default: return DUR_W'($urandom);
        endcase
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timings: field extremes, dropped strands, bit patterns
        send_cmd('0, '0, '0, '0, '0, '0);
        send_cmd(STRAND_W'(STRAND_COUNT - 1), '1, '1, '1, '1, '1);
        send_cmd(STRAND_W'(STRAND_COUNT), '1, '1, '1, '1, '1);
        send_random_payload(STRAND_W'(STRAND_COUNT + 1));
        send_random_payload(STRAND_W'(STRAND_MAX));
        send_cmd(3'd1, 6'h2A, 8'hAA, 4'hA, 4'h5, 4'hA);
        send_cmd(3'd2, 6'h15, 8'h55, 4'h5, 4'hA, 4'h5);
        send_cmd(3'd3, 6'h01, 8'h80, 4'h1, 4'h8, 4'h1);
        drain();

        // zero durations still give segments
        program_timings('0, '0, '0, '0, '0);
        send_random_payload(3'd0);
        send_cmd(3'd4, '1, '0, '1, '0, '1);
        drain();

        // longest durations
        program_timings(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX);
        send_random_payload(3'd2);
        send_cmd(3'd1, '0, '1, '0, '1, '0);
        drain();

        // distinct timings, then writes to unused indexes must change nothing
        program_timings(8'd1, 8'd2, 8'd3, 8'd4, 8'd5);
        for (int i = REG_ZERO_HIGH_TIME + 1; i <= CFG_IDX_MAX; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        send_cmd(3'd3, 6'h33, 8'hC3, 4'h9, 4'h6, 4'hC);
        send_cmd(3'd0, 6'h0C, 8'h3C, 4'h6, 4'h9, 4'h3);
        drain();

        // random phases, new timings between them
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_timings(pick_duration(), pick_duration(), pick_duration(),
                            pick_duration(), pick_duration());
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_ZERO_HIGH_TIME + 1, CFG_IDX_MAX)),
                          CFG_DATA_W'($urandom));
                cfg_wr_en <= 1'b0;
            end
            src_steady <= (p == STEADY_PHASE) || (p == BACKPRESS_PHASE);
            snk_steady <= (p == STEADY_PHASE);
            if (p == BACKPRESS_PHASE) begin
                stall_start <= 1'b1;
                @(posedge aclk);
                stall_start <= 1'b0;
            end else begin
                @(posedge aclk);
            end
            send_random_cmds(ITEMS_PER_PHASE);
            drain();
        end

        if (fail_count == 0)
            $display("tb_led_string_pulse_frame_encoder_core OK");
        else
            $display("tb_led_string_pulse_frame_encoder_core NOT OK");
        $finish;
    end

endmodule
